// ===== src/spts_pkg.sv =====
`timescale 1ns / 1ps
package spts_pkg;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REM_LOW = 3'd2,
    OP_SCALE   = 3'd3,
    OP_Q_COEF  = 3'd4,
    OP_Q_DEG   = 3'd5
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam int COEF_BITS = 64;
  localparam int HALF_BITS = 32;
  localparam int DEG_IN_BITS = 16;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [HALF_BITS-1:0] a;
    logic [HALF_BITS-1:0] b;
  } mul_req_t;

endpackage

// ===== src/spts_if.sv =====
`timescale 1ns / 1ps
// Input word channel: one operation per word.
interface spts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic signed [63:0] coefficient;
  logic [15:0] degree;

  modport source (output valid, mode, coefficient, degree, input ready);
  modport sink   (input valid, mode, coefficient, degree, output ready);
endinterface

// Result word channel: one result per operation.
interface spts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [63:0] value;

  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

// ===== src/sparse_polynomial_term_store_unit.sv =====
`timescale 1ns / 1ps
// Sparse polynomial term store. The terms live in one memory, highest degree
// first, and a small sequencer walks it one entry at a time; the block takes
// no new word until the current one is finished, but a finished result may
// wait in the output register while the next word is taken. The memory read
// is registered, so each walk step reads an entry, then uses it: a degree
// lookup compares each entry passed, an insert or delete writes each entry
// shifted, and a scale multiplies and writes back each term, as the 64-bit
// wrapped product is built from three passes through one 32 x 32 multiplier.
// Remove-lowest only lowers the count; a leading-degree query reads entry
// zero. No clearing pass is needed: only entries below the count are used.
module sparse_polynomial_term_store_unit #(
  parameter int MAX_TERMS   = 64,
  parameter int DEGREE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  spts_in_if.sink     in_ch,
  spts_out_if.source  out_ch
);
  import spts_pkg::*;

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int EW = DEGREE_BITS + COEF_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_EV, S_DECIDE, S_SHUP, S_SHUP_WR, S_SHDN, S_SHDN_WR,
    S_SCL_RD, S_SCL_M0, S_SCL_M1, S_SCL_M2, S_SCL_M3, S_LEAD_RD, S_LEAD_EV, S_DONE
  } state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [COEF_BITS-1:0]   coef_r;
  logic [DEGREE_BITS-1:0] deg_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          ptr_r;
  logic [CW-1:0]          pos_r;
  logic                   hit_r;
  logic [COEF_BITS-1:0]   cur_r;
  logic [DEGREE_BITS-1:0] rdeg_r;
  logic [HALF_BITS-1:0]   lo_r;
  logic [HALF_BITS-1:0]   hi_r;
  logic [1:0]             res_status_r;
  logic [COEF_BITS-1:0]   res_value_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [COEF_BITS-1:0]   out_value_r;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [DEGREE_BITS-1:0] rd_deg;
  logic [COEF_BITS-1:0]   rd_coef;
  logic [COEF_BITS-1:0]   sum;
  mul_req_t               mreq;
  logic [2*HALF_BITS-1:0] mprod;
  logic                   in_fire;
  logic [CW-1:0]          ptr_inc;

  assign rd_deg  = ram_rdata[EW-1:COEF_BITS];
  assign rd_coef = ram_rdata[COEF_BITS-1:0];
  assign sum     = cur_r + coef_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign ptr_inc = ptr_r + CW'(1);

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.value  = out_value_r;

  spts_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  spts_mul32 u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (mprod)
  );

  // Memory read address for the state that issues a read.
  always_comb begin
    unique case (state_r)
      S_SHDN:    ram_raddr = IW'(ptr_inc);
      S_SHUP:    ram_raddr = IW'(ptr_r - CW'(1));
      S_LEAD_RD: ram_raddr = '0;
      default:   ram_raddr = IW'(ptr_r);
    endcase
  end

  // Memory writes: coefficient update, shifts, new term and scaled terms.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IW'(ptr_r);
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_DECIDE: begin
        if (op_r == OP_ADD && hit_r && sum != '0) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pos_r);
          ram_wdata = {deg_r, sum};
        end
      end
      S_SHDN_WR, S_SHUP_WR: begin
        ram_we = 1'b1;
      end
      S_SHUP: begin
        if (ptr_r == pos_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pos_r);
          ram_wdata = {deg_r, coef_r};
        end
      end
      S_SCL_M3: begin
        ram_we    = 1'b1;
        ram_wdata = {rdeg_r, hi_r + mprod[HALF_BITS-1:0], lo_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Operand selection for the three partial products of a scale step.
  always_comb begin
    unique case (state_r)
      S_SCL_M0: mreq = '{a: rd_coef[HALF_BITS-1:0], b: coef_r[HALF_BITS-1:0]};
      S_SCL_M1: mreq = '{a: cur_r[HALF_BITS-1:0], b: coef_r[COEF_BITS-1:HALF_BITS]};
      S_SCL_M2: mreq = '{a: cur_r[COEF_BITS-1:HALF_BITS], b: coef_r[HALF_BITS-1:0]};
      default:  mreq = '0;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r         <= op_t'(in_ch.mode);
            coef_r       <= in_ch.coefficient;
            deg_r        <= DEGREE_BITS'(in_ch.degree);
            ptr_r        <= '0;
            res_status_r <= ST_REJECT;
            res_value_r  <= '0;
            state_r      <= S_DONE;
            priority case (in_ch.mode)
              OP_ADD: begin
                if (in_ch.coefficient != '0) state_r <= S_FIND_RD;
              end
              OP_REMOVE, OP_Q_COEF: state_r <= S_FIND_RD;
              OP_REM_LOW: begin
                if (count_r != '0) begin
                  count_r      <= count_r - CW'(1);
                  res_status_r <= ST_DONE;
                end
              end
              OP_SCALE: begin
                if (count_r != '0) state_r <= S_SCL_RD;
              end
              OP_Q_DEG: begin
                if (count_r != '0) state_r <= S_LEAD_RD;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_FIND_RD: begin
          if (ptr_r == count_r) begin
            hit_r   <= 1'b0;
            pos_r   <= ptr_r;
            state_r <= S_DECIDE;
          end else begin
            state_r <= S_FIND_EV;
          end
        end
        S_FIND_EV: begin
          if (rd_deg > deg_r) begin
            ptr_r   <= ptr_inc;
            state_r <= S_FIND_RD;
          end else begin
            pos_r   <= ptr_r;
            hit_r   <= (rd_deg == deg_r);
            cur_r   <= rd_coef;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_DONE;
          unique case (op_r)
            OP_ADD: begin
              if (hit_r) begin
                if (sum == '0) begin
                  ptr_r   <= pos_r;
                  state_r <= S_SHDN;
                end else begin
                  res_status_r <= ST_DONE;
                end
              end else if (count_r == CW'(MAX_TERMS)) begin
                res_status_r <= ST_FULL;
              end else begin
                ptr_r   <= count_r;
                state_r <= S_SHUP;
              end
            end
            OP_REMOVE: begin
              if (hit_r) begin
                ptr_r   <= pos_r;
                state_r <= S_SHDN;
              end
            end
            OP_Q_COEF: begin
              if (hit_r) begin
                res_status_r <= ST_DONE;
                res_value_r  <= cur_r;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_SHDN: begin
          if (ptr_inc >= count_r) begin
            count_r      <= count_r - CW'(1);
            res_status_r <= ST_DONE;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          ptr_r   <= ptr_inc;
          state_r <= S_SHDN;
        end
        S_SHUP: begin
          if (ptr_r == pos_r) begin
            count_r      <= count_r + CW'(1);
            res_status_r <= ST_DONE;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SHUP_WR;
          end
        end
        S_SHUP_WR: begin
          ptr_r   <= ptr_r - CW'(1);
          state_r <= S_SHUP;
        end
        S_SCL_RD: begin
          if (ptr_r == count_r) begin
            res_status_r <= ST_DONE;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_SCL_M0;
          end
        end
        S_SCL_M0: begin
          cur_r   <= rd_coef;
          rdeg_r  <= rd_deg;
          state_r <= S_SCL_M1;
        end
        S_SCL_M1: begin
          lo_r    <= mprod[HALF_BITS-1:0];
          hi_r    <= mprod[2*HALF_BITS-1:HALF_BITS];
          state_r <= S_SCL_M2;
        end
        S_SCL_M2: begin
          hi_r    <= hi_r + mprod[HALF_BITS-1:0];
          state_r <= S_SCL_M3;
        end
        S_SCL_M3: begin
          ptr_r   <= ptr_inc;
          state_r <= S_SCL_RD;
        end
        S_LEAD_RD: begin
          state_r <= S_LEAD_EV;
        end
        S_LEAD_EV: begin
          res_status_r <= ST_DONE;
          res_value_r  <= COEF_BITS'(rd_deg);
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/spts_ram.sv =====
`timescale 1ns / 1ps
// Generic one-write, one-read memory with registered read data.
module spts_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/spts_mul32.sv =====
`timescale 1ns / 1ps
// Shared 32 x 32 unsigned multiplier with a registered product.
module spts_mul32 (
  input  logic                    clk,
  input  spts_pkg::mul_req_t      req,
  output logic [2*spts_pkg::HALF_BITS-1:0] prod_r
);
  import spts_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

// ===== src/spts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the term store.
module spts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_value
);
  import spts_pkg::*;

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("result word changed while stalled");

  // Status is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_REJECT ||
                   out_status == ST_FULL))
    else $error("undefined status code");

  // Only a successful operation may carry a nonzero value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_value == '0)
    else $error("nonzero value on a failed operation");

  // The block is busy in the cycle after it takes a word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while previous one still in work");
endmodule

bind sparse_polynomial_term_store_unit spts_checker u_spts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_value  (out_ch.value)
);

// ===== tb/tb_pkg_note.sv =====
`timescale 1ns / 1ps
// Random helpers shared by the term store bench.
package spts_tb_pkg;
  import spts_pkg::*;

  // Picks a coefficient that is often small and mostly positive, sometimes extreme.
  function automatic logic signed [63:0] pick_coef();
    logic signed [63:0] c;
    case ($urandom_range(0, 5))
      0: c = {$urandom(), $urandom()};
      1: c = 64'sh8000_0000_0000_0000;
      2: c = 64'sh7fff_ffff_ffff_ffff;
      3: c = -$signed({32'd0, $urandom_range(1, 9)});
      default: c = 64'($urandom_range(1, 9));
    endcase
    return c;
  endfunction
endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import spts_pkg::*;
  import spts_tb_pkg::*;

  localparam int TERM_CAP = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spts_in_if  in_ch();
  spts_out_if out_ch();

  sparse_polynomial_term_store_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [1:0]         status;
    logic signed [63:0] value;
  } term_result_t;

  // Predicted polynomial: parallel arrays, highest degree first.
  logic [15:0]        poly_deg [TERM_CAP];
  logic signed [63:0] poly_coef[TERM_CAP];
  int                 poly_count = 0;

  term_result_t pending_results[$];
  int           error_count = 0;
  int           send_idle_pct = 7;
  int           recv_stall_pct = 87;
  int           idle_cycles = 0;

  // Finds the first entry whose degree is not above the given one.
  function automatic int locate_degree(logic [15:0] d);
    int i;
    i = 0;
    while (i < poly_count && poly_deg[i] > d) i++;
    return i;
  endfunction

  // Applies one operation to the predicted polynomial and returns the expected word.
  function automatic term_result_t apply_term_op(logic [2:0] mode, logic signed [63:0] c,
                                                 logic [15:0] d);
    term_result_t r;
    int pos;
    logic signed [63:0] sum;
    r.status = ST_REJECT;
    r.value = '0;
    pos = locate_degree(d);
    case (mode)
      OP_ADD: if (c != 0) begin
        if (pos < poly_count && poly_deg[pos] == d) begin
          sum = poly_coef[pos] + c;
          if (sum == 0) begin
            for (int i = pos; i < poly_count - 1; i++) begin
              poly_deg[i] = poly_deg[i+1];
              poly_coef[i] = poly_coef[i+1];
            end
            poly_count--;
          end else begin
            poly_coef[pos] = sum;
          end
          r.status = ST_DONE;
        end else if (poly_count >= TERM_CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = poly_count; i > pos; i--) begin
            poly_deg[i] = poly_deg[i-1];
            poly_coef[i] = poly_coef[i-1];
          end
          poly_deg[pos] = d;
          poly_coef[pos] = c;
          poly_count++;
          r.status = ST_DONE;
        end
      end
      OP_REMOVE: if (pos < poly_count && poly_deg[pos] == d) begin
        for (int i = pos; i < poly_count - 1; i++) begin
          poly_deg[i] = poly_deg[i+1];
          poly_coef[i] = poly_coef[i+1];
        end
        poly_count--;
        r.status = ST_DONE;
      end
      OP_REM_LOW: if (poly_count > 0) begin
        poly_count--;
        r.status = ST_DONE;
      end
      OP_SCALE: if (poly_count > 0) begin
        for (int i = 0; i < poly_count; i++) poly_coef[i] = poly_coef[i] * c;
        r.status = ST_DONE;
      end
      OP_Q_COEF: if (pos < poly_count && poly_deg[pos] == d) begin
        r.value = poly_coef[pos];
        r.status = ST_DONE;
      end
      OP_Q_DEG: if (poly_count > 0) begin
        r.value = {48'd0, poly_deg[0]};
        r.status = ST_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Sends one word, predicting its result when it is accepted. Valid stays high
  // after acceptance until the next word or an idle cycle replaces it; the block
  // is busy in the cycle after it takes a word, so nothing is taken twice.
  task automatic send_word(logic [2:0] mode, logic signed [63:0] c, logic [15:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.coefficient <= c;
    in_ch.degree <= d;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_term_op(mode, c, d));
  endtask

  // Receiver: random stall, then check each accepted word against the oldest prediction.
  always @(posedge clk) begin
    term_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", {62'd0, out_ch.status}, 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", {62'd0, out_ch.status}, {62'd0, want.status});
          if (out_ch.value !== want.value)
            report_mismatch("value", out_ch.value, want.value);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted word on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Empty-table cases, every operation, then fill to full and probe the edges.
  task automatic test_directed();
    send_word(OP_REM_LOW, 64'sd0, 16'd0);
    send_word(OP_SCALE, 64'sd3, 16'd0);
    send_word(OP_Q_DEG, 64'sd0, 16'd0);
    send_word(OP_Q_COEF, 64'sd0, 16'hffff);
    send_word(OP_REMOVE, 64'sd0, 16'd5);
    send_word(OP_ADD, 64'sd0, 16'd5);
    send_word(3'd6, 64'sd1, 16'd1);
    send_word(3'd7, -64'sd1, 16'hffff);
    send_word(OP_ADD, 64'sh7fff_ffff_ffff_ffff, 16'hffff);
    send_word(OP_ADD, 64'sh8000_0000_0000_0000, 16'd0);
    send_word(OP_ADD, 64'sd1, 16'hffff);
    send_word(OP_Q_COEF, 64'sd0, 16'hffff);
    send_word(OP_ADD, 64'sh7fff_ffff_ffff_ffff, 16'hffff);
    send_word(OP_Q_DEG, 64'sd0, 16'd0);
    send_word(OP_ADD, 64'sd5, 16'd0);
    send_word(OP_SCALE, -64'sd1, 16'd0);
    send_word(OP_Q_COEF, 64'sd0, 16'd0);
    send_word(OP_SCALE, 64'sd0, 16'd0);
    send_word(OP_Q_COEF, 64'sd0, 16'd0);
    send_word(OP_REMOVE, 64'sd0, 16'd0);
    send_word(OP_REM_LOW, 64'sd0, 16'd0);
    for (int i = 0; i < TERM_CAP; i++) send_word(OP_ADD, 64'sd1, 16'(i * 3 + 1));
    send_word(OP_ADD, 64'sd2, 16'd2);
    send_word(OP_ADD, -64'sd1, 16'd4);
    send_word(OP_ADD, 64'sd2, 16'd2);
  endtask

  // Random mix kept near a mid-sized table over a narrow degree range so hits are common.
  task automatic test_random(int words);
    logic [2:0]  mode;
    logic [15:0] d;
    for (int n = 0; n < words; n++) begin
      case ($urandom_range(0, 19))
        0,1,2,3,4,5,6: mode = OP_ADD;
        7,8: mode = OP_REMOVE;
        9: mode = OP_REM_LOW;
        10: mode = OP_SCALE;
        11,12,13,14: mode = OP_Q_COEF;
        15,16: mode = OP_Q_DEG;
        17: mode = 3'($urandom_range(6, 7));
        default: mode = (poly_count > 40) ? OP_REM_LOW : OP_ADD;
      endcase
      d = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 95));
      if (mode == OP_SCALE && $urandom_range(0, 3) != 0)
        send_word(mode, $signed(64'($urandom_range(0, 3))) - 64'sd1, d);
      else
        send_word(mode, pick_coef(), d);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = OP_ADD;
    in_ch.coefficient = '0;
    in_ch.degree = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    send_idle_pct = 87;
    recv_stall_pct = 7;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(400);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
